>>> hw/rtl/modinv_pkg.sv
`timescale 1ns / 1ps

package modinv_pkg;

  // Fixed widths of the ports.
  localparam int DataW    = 64;
  localparam int StatusW  = 2;
  localparam int ApbAddrW = 4;

  // Default operand width of the datapath.
  localparam int DefaultWidth = 64;

  // Result status codes.
  localparam logic [StatusW-1:0] StFound       = 2'd0;
  localparam logic [StatusW-1:0] StNoInverse   = 2'd1;
  localparam logic [StatusW-1:0] StUnsupported = 2'd2;

endpackage

>>> hw/rtl/modular_inverse_odd_modulus_core.sv
`timescale 1ns / 1ps
// Sequence from start to the done_o strobe: a load step, WIDTH restoring steps that
// reduce the value modulo m, 2*WIDTH binary GCD iterations and a final step that
// forms the result, which done_o reports from a register. An even modulus skips the
// reduction and GCD steps. A new start is taken only once the core is back in idle
// (busy low); the receiver cannot stall.
// Reset (asynchronous, active low) sets the modulus to 1 and returns to idle.
module modular_inverse_odd_modulus_core #(
  parameter int WIDTH = modinv_pkg::DefaultWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [modinv_pkg::DataW-1:0]  value_i,
  // Result channel
  output logic                          done_o,
  output logic [modinv_pkg::DataW-1:0]  inverse_o,
  output logic [modinv_pkg::StatusW-1:0] status_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [modinv_pkg::ApbAddrW-1:0] paddr,
  input  logic [modinv_pkg::DataW-1:0]  pwdata,
  output logic [modinv_pkg::DataW-1:0]  prdata,
  output logic                          pready
);
  import modinv_pkg::*;

  localparam int CntW = $clog2(2 * WIDTH);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRed  = 2'd1;
  localparam logic [1:0] SGcd  = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DataW-1:0]   modulus_q;
  logic [WIDTH-1:0]   x_q, x_d;
  logic [WIDTH-1:0]   a_q, a_d;
  logic [WIDTH-1:0]   b_q, b_d;
  logic [WIDTH-1:0]   u_q, u_d;
  logic [WIDTH-1:0]   uu_q, uu_d;
  logic               unsup_q, unsup_d;
  logic               done_q, done_d;
  logic [WIDTH-1:0]   inv_q, inv_d;
  logic [StatusW-1:0] status_q, status_d;

  logic [WIDTH-1:0]   m_w;
  logic               cfg_wr;
  logic               sel_reg0;

  // Reduction step signals.
  logic [WIDTH:0]     red_t;
  logic [WIDTH+1:0]   red_sub;
  logic [WIDTH-1:0]   red_r;

  // GCD step signals.
  logic               odd;
  logic               swap;
  logic [WIDTH:0]     dab;
  logic [WIDTH:0]     dba;
  logic [WIDTH-1:0]   a_step;
  logic [WIDTH+1:0]   duv;
  logic [WIDTH+1:0]   dvu;
  logic [WIDTH+1:0]   dsel;
  logic               brw;
  logic               par;
  logic [WIDTH+1:0]   madd;
  logic [WIDTH+1:0]   usum;

  assign m_w      = modulus_q[WIDTH-1:0];
  assign sel_reg0 = (paddr[ApbAddrW-1:3] == '0);
  assign cfg_wr   = psel & penable & pwrite & pready;

  // Configuration register access.
  assign pready = 1'b1;
  assign prdata = sel_reg0 ? modulus_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= DataW'(1);
    end else if (cfg_wr && sel_reg0) begin
      modulus_q <= pwdata;
    end
  end

  // One restoring division step: shift in the next value bit, subtract m if it fits.
  always_comb begin
    red_t   = {a_q, x_q[WIDTH-1]};
    red_sub = {1'b0, red_t} - {2'b00, m_w};
    red_r   = red_sub[WIDTH+1] ? red_t[WIDTH-1:0] : red_sub[WIDTH-1:0];
  end

  // One binary GCD iteration. Both differences are formed in parallel so that
  // the swap never needs a negation; the coefficient halving folds the modular
  // correction and the odd fix-up into a single add of 0, m or 2*m.
  always_comb begin
    odd    = a_q[0];
    dab    = {1'b0, a_q} - {1'b0, b_q};
    dba    = {1'b0, b_q} - {1'b0, a_q};
    swap   = odd & dab[WIDTH];
    a_step = swap ? dba[WIDTH-1:0] : dab[WIDTH-1:0];

    duv = {2'b00, u_q} - {2'b00, uu_q};
    dvu = {2'b00, uu_q} - {2'b00, u_q};
    if (!odd) begin
      dsel = {2'b00, u_q};
    end else if (swap) begin
      dsel = dvu;
    end else begin
      dsel = duv;
    end
    brw = dsel[WIDTH+1];
    par = dsel[0] ^ brw;
    if (brw & par) begin
      madd = {1'b0, m_w, 1'b0};
    end else if (brw | par) begin
      madd = {2'b00, m_w};
    end else begin
      madd = '0;
    end
    usum = dsel + madd;
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    x_d      = x_q;
    a_d      = a_q;
    b_d      = b_q;
    u_d      = u_q;
    uu_d     = uu_q;
    unsup_d  = unsup_q;
    done_d   = 1'b0;
    inv_d    = inv_q;
    status_d = status_q;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          x_d     = value_i[WIDTH-1:0];
          a_d     = '0;
          b_d     = m_w;
          u_d     = (m_w == WIDTH'(1)) ? '0 : WIDTH'(1);
          uu_d    = '0;
          unsup_d = ~m_w[0];
          cnt_d   = CntW'(WIDTH - 1);
          state_d = m_w[0] ? SRed : SFin;
        end
      end
      SRed: begin
        a_d = red_r;
        x_d = {x_q[WIDTH-2:0], 1'b0};
        if (cnt_q == '0) begin
          cnt_d   = CntW'(2 * WIDTH - 1);
          state_d = SGcd;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SGcd: begin
        a_d  = (odd ? a_step : a_q) >> 1;
        b_d  = swap ? a_q : b_q;
        u_d  = usum[WIDTH:1];
        uu_d = swap ? u_q : uu_q;
        if (cnt_q == '0) begin
          state_d = SFin;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SFin: begin
        done_d  = 1'b1;
        state_d = SIdle;
        if (unsup_q) begin
          inv_d    = '0;
          status_d = StUnsupported;
        end else if (b_q == WIDTH'(1)) begin
          inv_d    = uu_q;
          status_d = StFound;
        end else begin
          inv_d    = '0;
          status_d = StNoInverse;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    a_q      <= a_d;
    b_q      <= b_d;
    u_q      <= u_d;
    uu_q     <= uu_d;
    unsup_q  <= unsup_d;
    inv_q    <= inv_d;
    status_q <= status_d;
  end

  assign busy      = (state_q != SIdle);
  assign done_o    = done_q;
  assign inverse_o = DataW'(inv_q);
  assign status_o  = status_q;

endmodule
